FILE: sv/ihr_pkg.sv
// ----------------------------------------------------------------------------
// IPv4 header rewriter package
// Shared types, codes and the incremental checksum helper.
// ----------------------------------------------------------------------------
package ihr_pkg;

  localparam int unsigned IP_HEADER_OFFSET_DEF = 14;
  localparam int unsigned QUEUE_DEPTH_DEF      = 4;

  localparam logic [7:0]  NEW_TTL_RESET = 8'd64;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 16;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_TTL  = 2'd1,
    MODE_DSCP = 2'd2,
    MODE_PORT = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE        = 3'd0,
    CFG_NEW_TTL     = 3'd1,
    CFG_NEW_DSCP    = 3'd2,
    CFG_MATCH_PORT  = 3'd3,
    CFG_TARGET_PORT = 3'd4
  } cfg_idx_e;

  // Pending action of the current frame.
  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_DST  = 2'd1,
    ACT_SRC  = 2'd2,
    ACT_IP   = 2'd3
  } act_e;

  typedef struct packed {
    mode_e       mode;
    logic [7:0]  new_ttl;
    logic [5:0]  new_dscp;
    logic [15:0] match_port;
    logic [15:0] target_port;
  } cfg_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        out_last;
    logic [31:0] rewrite_total;
  } out_item_t;

  // One group of one to four result bytes caused by a single request.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      n_m1;
    logic            last;
    logic [31:0]     total;
  } group_t;

  // Ones-complement checksum update: ~(~HC + ~m + m').
  function automatic logic [15:0] csum_patch(input logic [15:0] hc,
                                             input logic [15:0] old_w,
                                             input logic [15:0] new_w);
    logic [17:0] s0;
    logic [16:0] s1;
    logic [16:0] s2;
    s0 = {2'b00, ~hc} + {2'b00, ~old_w} + {2'b00, new_w};
    s1 = {1'b0, s0[15:0]} + {15'd0, s0[17:16]};
    s2 = {1'b0, s1[15:0]} + {16'd0, s1[16]};
    return ~s2[15:0];
  endfunction

endpackage

FILE: sv/ipv4_header_rewriter.sv
// ----------------------------------------------------------------------------
// IPv4 header rewriter: TTL, DSCP and TCP port rewrite with checksum patch
// Path: a pass-through byte is stored in the group queue, then in the back end's current group.
// Throughput: one byte per cycle in unless full, out if popped, held port and checksum bytes too.
// Reset: all control state, the rewrite count and queue pointers clear; data storage has no reset.
// ----------------------------------------------------------------------------
module ipv4_header_rewriter #(
  parameter int unsigned IP_HEADER_OFFSET = ihr_pkg::IP_HEADER_OFFSET_DEF,
  parameter int unsigned QUEUE_DEPTH      = ihr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write port.
  input  logic                             cfg_we_i,
  input  logic [ihr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ihr_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  // Input side, seen as the write side of a queue.
  input  logic                             push,
  output logic                             full,
  input  ihr_pkg::in_item_t                in_item_i,
  // Result side, seen as the read side of a queue.
  output logic                             empty,
  input  logic                             pop,
  output ihr_pkg::out_item_t               out_item_o
);

  // The front end parses every accepted byte in the cycle of its request and
  // turns it into a group of zero to four result bytes. Port bytes of a TCP
  // header are held inside the front end until all four are seen, and a
  // checksum high byte that needs a patch is held until its low byte arrives,
  // so a single request may release up to four bytes at once. Those groups go
  // through a short queue to the back end, which hands them out one byte per
  // pop. Since held bytes are balanced by requests that produced nothing, the
  // back end keeps up with one request per cycle on average and the queue
  // absorbs the bursts.

  ihr_pkg::cfg_t   cfg_q;
  logic            accept;
  logic            grp_valid;
  ihr_pkg::group_t grp;
  logic            q_valid;
  logic            q_pop;
  ihr_pkg::group_t q_data;

  // Configuration registers; indices beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode        <= ihr_pkg::MODE_OFF;
      cfg_q.new_ttl     <= ihr_pkg::NEW_TTL_RESET;
      cfg_q.new_dscp    <= '0;
      cfg_q.match_port  <= '0;
      cfg_q.target_port <= '0;
    end else if (cfg_we_i) begin
      case (ihr_pkg::cfg_idx_e'(cfg_idx_i))
        ihr_pkg::CFG_MODE:        cfg_q.mode        <= ihr_pkg::mode_e'(cfg_wdata_i[1:0]);
        ihr_pkg::CFG_NEW_TTL:     cfg_q.new_ttl     <= cfg_wdata_i[7:0];
        ihr_pkg::CFG_NEW_DSCP:    cfg_q.new_dscp    <= cfg_wdata_i[5:0];
        ihr_pkg::CFG_MATCH_PORT:  cfg_q.match_port  <= cfg_wdata_i[15:0];
        ihr_pkg::CFG_TARGET_PORT: cfg_q.target_port <= cfg_wdata_i[15:0];
        default: begin
        end
      endcase
    end
  end

  // A request is taken whenever the queue has room for the group it may make.
  assign accept = push && !full;

  ihr_front #(
    .IP_HEADER_OFFSET(IP_HEADER_OFFSET)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (in_item_i),
    .cfg_i       (cfg_q),
    .grp_valid_o (grp_valid),
    .grp_o       (grp)
  );

  ihr_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (grp_valid),
    .data_i  (grp),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  // The back end holds the group being played out, so a finished result can
  // wait for its pop while the front end keeps taking requests.
  ihr_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_data),
    .q_pop_o   (q_pop),
    .pop_i     (pop),
    .empty_o   (empty),
    .item_o    (out_item_o)
  );

endmodule

FILE: sv/ihr_front.sv
// ----------------------------------------------------------------------------
// IPv4 header rewriter front end
// Parses each accepted byte, applies the rewrite and emits a result group unless it holds the byte.
// ----------------------------------------------------------------------------
module ihr_front #(
  parameter int unsigned IP_HEADER_OFFSET = ihr_pkg::IP_HEADER_OFFSET_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  ihr_pkg::in_item_t item_i,
  input  ihr_pkg::cfg_t     cfg_i,
  output logic              grp_valid_o,
  output ihr_pkg::group_t   grp_o
);

  localparam bit          HAS_ETYPE = (IP_HEADER_OFFSET >= 2);
  localparam logic [15:0] OFF       = 16'(IP_HEADER_OFFSET);
  localparam logic [15:0] ETYPE_HI_POS = HAS_ETYPE ? 16'(int'(IP_HEADER_OFFSET) - 2) : 16'd0;
  localparam logic [15:0] ETYPE_LO_POS = HAS_ETYPE ? 16'(int'(IP_HEADER_OFFSET) - 1) : 16'd0;
  localparam logic [15:0] POS_TOS    = OFF + 16'd1;
  localparam logic [15:0] POS_TTL    = OFF + 16'd8;
  localparam logic [15:0] POS_PROTO  = OFF + 16'd9;
  localparam logic [15:0] POS_CSUM_H = OFF + 16'd10;
  localparam logic [15:0] POS_CSUM_L = OFF + 16'd11;
  localparam logic [15:0] TCP_CSUM_H = 16'd16;
  localparam logic [15:0] TCP_CSUM_L = 16'd17;
  localparam logic [7:0]  ETYPE_HI   = 8'h08;
  localparam logic [7:0]  ETYPE_LO   = 8'h00;
  localparam logic [3:0]  IP_V4      = 4'd4;
  localparam logic [3:0]  IHL_MIN    = 4'd5;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;

  logic [15:0]        pos_q, pos_d;
  logic               ipv4_q, ipv4_d;
  logic [7:0]         vih_q, vih_d;
  logic [7:0]         tos_q, tos_d;
  logic [7:0]         ttl_q, ttl_d;
  logic [7:0]         prot_q, prot_d;
  logic [7:0]         chk_q, chk_d;
  logic [3:0][7:0]    buf_q, buf_d;
  logic [2:0]         hc_q, hc_d;
  ihr_pkg::act_e      act_q, act_d;
  logic [31:0]        cnt_q, cnt_d;
  logic [15:0]        oldw_q, oldw_d;
  logic [15:0]        neww_q, neww_d;
  logic [7:0]         ipnew_q, ipnew_d;
  logic               is_ttl_q, is_ttl_d;

  logic [7:0]  b;
  logic        last;
  logic        done;
  logic        emit;
  logic [7:0]  outb;
  logic [7:0]  new_tos;
  logic [15:0] ow, nw, nc;
  logic [15:0] tcp_pos;
  logic [2:0]  hcn;
  logic [15:0] sp, dp;
  logic        port_act;

  assign b    = item_i.in_byte;
  assign last = item_i.in_last;

  always_comb begin
    pos_d    = pos_q;
    ipv4_d   = ipv4_q;
    vih_d    = vih_q;
    tos_d    = tos_q;
    ttl_d    = ttl_q;
    prot_d   = prot_q;
    chk_d    = chk_q;
    buf_d    = buf_q;
    hc_d     = hc_q;
    act_d    = act_q;
    cnt_d    = cnt_q;
    oldw_d   = oldw_q;
    neww_d   = neww_q;
    ipnew_d  = ipnew_q;
    is_ttl_d = is_ttl_q;
    done     = 1'b0;
    emit     = 1'b0;
    outb     = b;
    new_tos  = {cfg_i.new_dscp, b[1:0]};
    ow       = '0;
    nw       = '0;
    nc       = '0;
    hcn      = '0;
    sp       = '0;
    dp       = '0;
    port_act = 1'b0;
    tcp_pos  = '0;
    grp_o    = '0;

    // Frame start clears per-frame state.
    if (pos_q == 16'd0) begin
      ipv4_d = !HAS_ETYPE;
      vih_d  = '0;
      prot_d = '0;
      act_d  = ihr_pkg::ACT_NONE;
      hc_d   = '0;
    end
    if (HAS_ETYPE && pos_q == ETYPE_HI_POS) begin
      ipv4_d = (b == ETYPE_HI);
    end
    if (HAS_ETYPE && pos_q == ETYPE_LO_POS) begin
      ipv4_d = ipv4_d && (b == ETYPE_LO);
    end
    if (pos_q == OFF) begin
      vih_d  = b;
      ipv4_d = ipv4_d && (b[7:4] == IP_V4);
    end

    if (ipv4_d && pos_q > OFF) begin
      if (pos_q == POS_TOS) begin
        tos_d = b;
        if (cfg_i.mode == ihr_pkg::MODE_DSCP && act_d == ihr_pkg::ACT_NONE &&
            new_tos != b) begin
          outb     = new_tos;
          ipnew_d  = new_tos;
          is_ttl_d = 1'b0;
          act_d    = ihr_pkg::ACT_IP;
          cnt_d    = cnt_d + 32'd1;
        end
      end else if (pos_q == POS_TTL) begin
        ttl_d = b;
        if (cfg_i.mode == ihr_pkg::MODE_TTL && act_d == ihr_pkg::ACT_NONE &&
            b != cfg_i.new_ttl) begin
          outb     = cfg_i.new_ttl;
          ipnew_d  = cfg_i.new_ttl;
          is_ttl_d = 1'b1;
          act_d    = ihr_pkg::ACT_IP;
          cnt_d    = cnt_d + 32'd1;
        end
      end else if (pos_q == POS_PROTO) begin
        prot_d = b;
      end else if (pos_q == POS_CSUM_H) begin
        if (act_d == ihr_pkg::ACT_IP && !last) begin
          chk_d = b;
          hc_d  = 3'd1;
          done  = 1'b1;
        end
      end else if (pos_q == POS_CSUM_L) begin
        if (act_d == ihr_pkg::ACT_IP && hc_d == 3'd1) begin
          if (is_ttl_d) begin
            ow = {ttl_d, prot_d};
            nw = {ipnew_d, prot_d};
          end else begin
            ow = {vih_d, tos_d};
            nw = {vih_d, ipnew_d};
          end
          nc    = ihr_pkg::csum_patch({chk_d, b}, ow, nw);
          hc_d  = '0;
          act_d = ihr_pkg::ACT_NONE;
          grp_o.bytes[0] = nc[15:8];
          grp_o.bytes[1] = nc[7:0];
          grp_o.n_m1     = 2'd1;
          emit = 1'b1;
          done = 1'b1;
        end
      end
    end

    tcp_pos  = OFF + {10'd0, vih_d[3:0], 2'b00};
    port_act = (act_d == ihr_pkg::ACT_DST) || (act_d == ihr_pkg::ACT_SRC);
    if (!done && ipv4_d && vih_d[3:0] >= IHL_MIN && prot_d == PROTO_TCP &&
        pos_q > POS_CSUM_L) begin
      if (pos_q >= tcp_pos && pos_q <= tcp_pos + 16'd3 &&
          (hc_d != 3'd0 || (pos_q == tcp_pos && cfg_i.mode == ihr_pkg::MODE_PORT &&
                            act_d == ihr_pkg::ACT_NONE))) begin
        // Hold the four port bytes until the decision can be made.
        buf_d[hc_d[1:0]] = b;
        hcn = hc_d + 3'd1;
        grp_o.n_m1 = hc_d[1:0];
        if (hcn >= 3'd4) begin
          sp = {buf_d[0], buf_d[1]};
          dp = {buf_d[2], buf_d[3]};
          if (dp == cfg_i.match_port) begin
            oldw_d   = dp;
            neww_d   = cfg_i.target_port;
            buf_d[2] = cfg_i.target_port[15:8];
            buf_d[3] = cfg_i.target_port[7:0];
            act_d    = ihr_pkg::ACT_DST;
            cnt_d    = cnt_d + 32'd1;
          end else if (sp == cfg_i.target_port) begin
            oldw_d   = sp;
            neww_d   = cfg_i.match_port;
            buf_d[0] = cfg_i.match_port[15:8];
            buf_d[1] = cfg_i.match_port[7:0];
            act_d    = ihr_pkg::ACT_SRC;
            cnt_d    = cnt_d + 32'd1;
          end
          hc_d = '0;
          emit = 1'b1;
        end else if (last) begin
          // Truncated mid-port: release what was held, unpatched.
          hc_d = '0;
          emit = 1'b1;
        end else begin
          hc_d = hcn;
        end
        grp_o.bytes = buf_d;
        done = 1'b1;
      end else if (pos_q == tcp_pos + TCP_CSUM_H && port_act && !last) begin
        chk_d = b;
        hc_d  = 3'd1;
        done  = 1'b1;
      end else if (pos_q == tcp_pos + TCP_CSUM_L && port_act && hc_d == 3'd1) begin
        nc    = ihr_pkg::csum_patch({chk_d, b}, oldw_d, neww_d);
        hc_d  = '0;
        act_d = ihr_pkg::ACT_NONE;
        grp_o.bytes[0] = nc[15:8];
        grp_o.bytes[1] = nc[7:0];
        grp_o.n_m1     = 2'd1;
        emit = 1'b1;
        done = 1'b1;
      end
    end

    if (!done) begin
      grp_o.bytes[0] = outb;
      grp_o.n_m1     = 2'd0;
      emit = 1'b1;
    end

    grp_o.last  = last;
    grp_o.total = cnt_d;

    if (last) begin
      pos_d = '0;
    end else if (pos_q != 16'hffff) begin
      pos_d = pos_q + 16'd1;
    end
  end

  assign grp_valid_o = accept_i && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      ipv4_q   <= 1'b0;
      vih_q    <= '0;
      tos_q    <= '0;
      ttl_q    <= '0;
      prot_q   <= '0;
      chk_q    <= '0;
      hc_q     <= '0;
      act_q    <= ihr_pkg::ACT_NONE;
      cnt_q    <= '0;
      oldw_q   <= '0;
      neww_q   <= '0;
      ipnew_q  <= '0;
      is_ttl_q <= 1'b0;
    end else if (accept_i) begin
      pos_q    <= pos_d;
      ipv4_q   <= ipv4_d;
      vih_q    <= vih_d;
      tos_q    <= tos_d;
      ttl_q    <= ttl_d;
      prot_q   <= prot_d;
      chk_q    <= chk_d;
      hc_q     <= hc_d;
      act_q    <= act_d;
      cnt_q    <= cnt_d;
      oldw_q   <= oldw_d;
      neww_q   <= neww_d;
      ipnew_q  <= ipnew_d;
      is_ttl_q <= is_ttl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      buf_q <= buf_d;
    end
  end

  // No more than three bytes are ever held between requests.
  a_hold_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hc_q <= 3'd3)
    else $error("front holds more than three bytes");

endmodule

FILE: sv/ihr_queue.sv
// ----------------------------------------------------------------------------
// IPv4 header rewriter group queue
// Short queue of result groups between the front and back ends.
// ----------------------------------------------------------------------------
module ihr_queue #(
  parameter int unsigned DEPTH = ihr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ihr_pkg::group_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output ihr_pkg::group_t data_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  ihr_pkg::group_t mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("group queue count exceeds its depth");

endmodule

FILE: sv/ihr_back.sv
// ----------------------------------------------------------------------------
// IPv4 header rewriter back end
// Plays each result group out one byte per request on the result side.
// ----------------------------------------------------------------------------
module ihr_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  ihr_pkg::group_t    q_data_i,
  output logic               q_pop_o,
  input  logic               pop_i,
  output logic               empty_o,
  output ihr_pkg::out_item_t item_o
);

  ihr_pkg::group_t cur_q;
  logic            cur_valid_q;
  logic [1:0]      idx_q;
  logic            at_end;
  logic            take;

  assign at_end  = (idx_q == cur_q.n_m1);
  assign take    = cur_valid_q && pop_i;
  assign q_pop_o = q_valid_i && (!cur_valid_q || (take && at_end));
  assign empty_o = !cur_valid_q;

  assign item_o.out_byte      = cur_q.bytes[idx_q];
  assign item_o.out_last      = cur_q.last && at_end;
  assign item_o.rewrite_total = cur_q.total;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (q_pop_o) begin
      cur_valid_q <= 1'b1;
      idx_q       <= '0;
    end else if (take) begin
      if (at_end) begin
        cur_valid_q <= 1'b0;
        idx_q       <= '0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_data_i;
    end
  end

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q |-> (idx_q <= cur_q.n_m1))
    else $error("back end index runs past its group");

endmodule
